// ===== hdl/lrc_pkg.sv =====
// Shared types and constants for the LRU result cache.
// No dependencies; imported by every module of the block except lrc_ram.
`default_nettype none

package lrc_pkg;

    localparam int ENTRIES       = 256;
    localparam int KEY_WIDTH     = 64;
    localparam int PAYLOAD_WIDTH = 32;
    localparam int CAP_WIDTH     = 9;
    localparam int STATUS_WIDTH  = 3;
    localparam int IDX_W         = $clog2(ENTRIES);
    localparam int CNT_W         = $clog2(ENTRIES + 1);

    localparam logic [CAP_WIDTH-1:0] CAP_RESET = 9'd256;

    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_INSERT = 1'b1;

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_MISS   = 3'd0,
        ST_HIT    = 3'd1,
        ST_STORED = 3'd2,
        ST_EVICT  = 3'd3,
        ST_DUP    = 3'd4,
        ST_OFF    = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_HIT_VAL,
        S_EV_ORD,
        S_EV_TAG,
        S_WALK_START,
        S_WALK,
        S_FINISH
    } eng_state_t;

    typedef struct packed {
        logic                     kind;
        logic [KEY_WIDTH-1:0]     key;
        logic [PAYLOAD_WIDTH-1:0] payload;
    } req_t;

    typedef struct packed {
        status_t                  status;
        logic [PAYLOAD_WIDTH-1:0] data;
        logic [KEY_WIDTH-1:0]     evicted_key;
    } resp_t;

    // capacity seen by the engine, plus a one-cycle clear on a register write
    typedef struct packed {
        logic             clear;
        logic [CNT_W-1:0] cap;
    } cfg_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/lru_result_cache_unit.sv =====
// Top level of the LRU result cache: channels, capacity register, result register.
// Depends on lrc_pkg and lrc_engine.
//
//  channel  dir  handshake            payload
//  s_       in   s_valid / s_ready    s_kind, s_key, s_payload
//  m_       out  m_valid / m_ready    m_status, m_data, m_evicted_key
//  cfg_     in   cfg_valid / cfg_ready cfg_data (capacity)
//
// One item at a time. The tag scan reads one slot a cycle over the n entries held
// and compares it in the next cycle, stopping at a match. A miss, duplicate or
// disabled insert then finishes; a hit reads its value, a store writes the next free
// slot, an eviction reads the least recent slot and its tag; each then rotates the
// recency order. The finish state holds while the output register waits on m_ready,
// and s_ready rises once idle. Reset (capacity 256) or a capacity write empties it.
`default_nettype none

module lru_result_cache_unit
    import lrc_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic                     s_kind,
    input  wire logic [KEY_WIDTH-1:0]     s_key,
    input  wire logic [PAYLOAD_WIDTH-1:0] s_payload,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [STATUS_WIDTH-1:0]       m_status,
    output logic [PAYLOAD_WIDTH-1:0]      m_data,
    output logic [KEY_WIDTH-1:0]          m_evicted_key,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CAP_WIDTH-1:0]     cfg_data
);

    logic [CAP_WIDTH-1:0] capacity_reg, capacity_next;
    logic                 m_valid_reg,  m_valid_next;
    resp_t                out_reg,      out_next;

    req_t     req_in;
    cfg_ctl_t cfg_ctl;
    resp_t    eng_resp;
    logic     eng_idle;
    logic     eng_resp_valid;
    logic     resp_taken;
    logic     start;
    logic     cfg_write;

    // capacity register
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb begin
        capacity_next = capacity_reg;
        if (cfg_write) begin
            capacity_next = cfg_data;
        end
    end

    // clamp to the number of slots
    assign cfg_ctl.clear = cfg_write;
    assign cfg_ctl.cap   = (int'(capacity_reg) > ENTRIES) ? CNT_W'(ENTRIES)
                                                          : CNT_W'(capacity_reg);

    // input beat
    assign s_ready        = eng_idle;
    assign start          = s_valid && s_ready;
    assign req_in.kind    = s_kind;
    assign req_in.key     = s_key;
    assign req_in.payload = s_payload;

    lrc_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (start),
        .req_in     (req_in),
        .idle       (eng_idle),
        .cfg_ctl    (cfg_ctl),
        .resp_valid (eng_resp_valid),
        .resp_taken (resp_taken),
        .resp       (eng_resp)
    );

    // output register
    assign resp_taken = eng_resp_valid && (!m_valid_reg || m_ready);

    always_comb begin
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (resp_taken) begin
            m_valid_next = 1'b1;
            out_next     = eng_resp;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_RESET;
            m_valid_reg  <= 1'b0;
        end else begin
            capacity_reg <= capacity_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = out_reg.status;
    assign m_data        = out_reg.data;
    assign m_evicted_key = out_reg.evicted_key;

endmodule

`default_nettype wire

// ===== hdl/lrc_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No package dependencies.
`default_nettype none

module lrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/lrc_cmp.sv =====
// Shared equality unit used by the tag scan and the recency walk.
// Depends on lrc_pkg.
`default_nettype none

module lrc_cmp
    import lrc_pkg::*;
(
    input  wire logic [KEY_WIDTH-1:0] a,
    input  wire logic [KEY_WIDTH-1:0] b,
    output logic                      eq
);

    assign eq = (a == b);

endmodule

`default_nettype wire

// ===== hdl/lrc_engine.sv =====
// Sequencer and datapath of the LRU cache: tag scan, decision, recency walk.
// Depends on lrc_pkg, lrc_ram and lrc_cmp.
`default_nettype none

module lrc_engine
    import lrc_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     start,
    input  wire req_t     req_in,
    output logic          idle,
    input  wire cfg_ctl_t cfg_ctl,
    output logic          resp_valid,
    input  wire logic     resp_taken,
    output resp_t         resp
);

    eng_state_t state_reg, state_next;

    logic [CNT_W-1:0] idx_reg,   idx_next;
    logic             pend_reg,  pend_next;
    logic [IDX_W-1:0] prev_reg,  prev_next;
    logic             hit_reg,   hit_next;
    logic [IDX_W-1:0] slot_reg,  slot_next;
    logic [IDX_W-1:0] carry_reg, carry_next;
    logic [CNT_W-1:0] limit_reg, limit_next;
    logic [CNT_W-1:0] occ_reg,   occ_next;
    req_t             req_reg,   req_next;
    resp_t            resp_reg,  resp_next;

    // memory ports
    logic                     tag_we,  val_we,  ord_we;
    logic [IDX_W-1:0]         tag_waddr, val_waddr, ord_waddr;
    logic [IDX_W-1:0]         tag_raddr, val_raddr, ord_raddr;
    logic [KEY_WIDTH-1:0]     tag_rdata;
    logic [PAYLOAD_WIDTH-1:0] val_rdata;
    logic [IDX_W-1:0]         ord_rdata;

    // shared compare unit
    logic [KEY_WIDTH-1:0] cmp_a, cmp_b;
    logic                 cmp_eq;

    logic walk_stop;
    logic scan_match;

    lrc_ram #(.WIDTH(KEY_WIDTH), .DEPTH(ENTRIES)) u_tag_ram (
        .aclk  (aclk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (req_reg.key),
        .raddr (tag_raddr),
        .rdata (tag_rdata)
    );

    lrc_ram #(.WIDTH(PAYLOAD_WIDTH), .DEPTH(ENTRIES)) u_val_ram (
        .aclk  (aclk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (req_reg.payload),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

    // recency order: position -> slot, most recent at position zero
    lrc_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_ord_ram (
        .aclk  (aclk),
        .we    (ord_we),
        .waddr (ord_waddr),
        .wdata (carry_reg),
        .raddr (ord_raddr),
        .rdata (ord_rdata)
    );

    lrc_cmp u_cmp (
        .a  (cmp_a),
        .b  (cmp_b),
        .eq (cmp_eq)
    );

    // operand select for the shared compare
    always_comb begin
        if (state_reg == S_WALK) begin
            cmp_a = {{(KEY_WIDTH-IDX_W){1'b0}}, ord_rdata};
            cmp_b = {{(KEY_WIDTH-IDX_W){1'b0}}, slot_reg};
        end else begin
            cmp_a = tag_rdata;
            cmp_b = req_reg.key;
        end
    end

    assign scan_match = pend_reg && cmp_eq;
    assign walk_stop  = cmp_eq || (idx_reg == limit_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_match || (idx_reg == occ_reg)) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (req_reg.kind == KIND_LOOKUP) begin
                    state_next = hit_reg ? S_HIT_VAL : S_FINISH;
                end else if ((cfg_ctl.cap == '0) || hit_reg) begin
                    state_next = S_FINISH;
                end else if (occ_reg < cfg_ctl.cap) begin
                    state_next = S_WALK_START;
                end else begin
                    state_next = S_EV_ORD;
                end
            end
            S_HIT_VAL:    state_next = S_WALK_START;
            S_EV_ORD:     state_next = S_EV_TAG;
            S_EV_TAG:     state_next = S_WALK_START;
            S_WALK_START: state_next = S_WALK;
            S_WALK: begin
                if (walk_stop) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (resp_taken) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        idx_next   = idx_reg;
        pend_next  = pend_reg;
        prev_next  = prev_reg;
        hit_next   = hit_reg;
        slot_next  = slot_reg;
        carry_next = carry_reg;
        limit_next = limit_reg;
        occ_next   = occ_reg;
        req_next   = req_reg;
        resp_next  = resp_reg;
        tag_we     = 1'b0;
        val_we     = 1'b0;
        ord_we     = 1'b0;
        tag_waddr  = slot_reg;
        val_waddr  = slot_reg;
        ord_waddr  = idx_reg[IDX_W-1:0];
        tag_raddr  = idx_reg[IDX_W-1:0];
        val_raddr  = slot_reg;
        ord_raddr  = idx_reg[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    req_next              = req_in;
                    idx_next              = '0;
                    pend_next             = 1'b0;
                    hit_next              = 1'b0;
                    resp_next.status      = ST_MISS;
                    resp_next.data        = '0;
                    resp_next.evicted_key = '0;
                end
            end
            // one slot issued per cycle, compared in the next cycle
            S_SCAN: begin
                if (scan_match) begin
                    hit_next  = 1'b1;
                    slot_next = prev_reg;
                end else if (idx_reg != occ_reg) begin
                    prev_next = idx_reg[IDX_W-1:0];
                    idx_next  = idx_reg + CNT_W'(1);
                    pend_next = 1'b1;
                end
            end
            S_DECIDE: begin
                if (req_reg.kind == KIND_LOOKUP) begin
                    if (hit_reg) begin
                        carry_next       = slot_reg;
                        limit_next       = occ_reg;
                        resp_next.status = ST_HIT;
                    end
                end else if (cfg_ctl.cap == '0) begin
                    resp_next.status = ST_OFF;
                end else if (hit_reg) begin
                    resp_next.status = ST_DUP;
                end else if (occ_reg < cfg_ctl.cap) begin
                    // new entry goes into the next free slot
                    tag_we           = 1'b1;
                    val_we           = 1'b1;
                    tag_waddr        = occ_reg[IDX_W-1:0];
                    val_waddr        = occ_reg[IDX_W-1:0];
                    slot_next        = occ_reg[IDX_W-1:0];
                    carry_next       = occ_reg[IDX_W-1:0];
                    limit_next       = occ_reg;
                    occ_next         = occ_reg + CNT_W'(1);
                    resp_next.status = ST_STORED;
                end else begin
                    // fetch the slot at the least recent position
                    ord_raddr        = IDX_W'(occ_reg - CNT_W'(1));
                    resp_next.status = ST_EVICT;
                end
            end
            S_HIT_VAL: begin
                resp_next.data = val_rdata;
            end
            S_EV_ORD: begin
                slot_next  = ord_rdata;
                carry_next = ord_rdata;
                tag_raddr  = ord_rdata;
                limit_next = occ_reg - CNT_W'(1);
            end
            S_EV_TAG: begin
                resp_next.evicted_key = tag_rdata;
                tag_we                = 1'b1;
                val_we                = 1'b1;
            end
            S_WALK_START: begin
                ord_raddr = '0;
                idx_next  = '0;
            end
            // rotate the prefix: write the carried slot, carry the old one on
            S_WALK: begin
                ord_we = 1'b1;
                if (!walk_stop) begin
                    carry_next = ord_rdata;
                    idx_next   = idx_reg + CNT_W'(1);
                    ord_raddr  = IDX_W'(idx_reg + CNT_W'(1));
                end
            end
            S_FINISH: begin
            end
            default: begin
            end
        endcase

        if (cfg_ctl.clear) begin
            occ_next = '0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            occ_reg   <= '0;
            pend_reg  <= 1'b0;
            hit_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            pend_reg  <= pend_next;
            hit_reg   <= hit_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        idx_reg   <= idx_next;
        prev_reg  <= prev_next;
        slot_reg  <= slot_next;
        carry_reg <= carry_next;
        limit_reg <= limit_next;
        req_reg   <= req_next;
        resp_reg  <= resp_next;
    end

    assign idle       = (state_reg == S_IDLE);
    assign resp_valid = (state_reg == S_FINISH);
    assign resp       = resp_reg;

endmodule

`default_nettype wire

// ===== bench/lru_cache_checker.sv =====
`timescale 1ns / 1ps
// Checker for the LRU result cache: watches request, response and capacity beats,
// predicts each response and compares it field by field. Depends on lrc_pkg.

module lru_cache_checker
    import lrc_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    input  wire logic                     s_ready,
    input  wire logic                     s_kind,
    input  wire logic [KEY_WIDTH-1:0]     s_key,
    input  wire logic [PAYLOAD_WIDTH-1:0] s_payload,
    input  wire logic                     m_valid,
    input  wire logic                     m_ready,
    input  wire logic [STATUS_WIDTH-1:0]  m_status,
    input  wire logic [PAYLOAD_WIDTH-1:0] m_data,
    input  wire logic [KEY_WIDTH-1:0]     m_evicted_key,
    input  wire logic                     cfg_valid,
    input  wire logic                     cfg_ready,
    input  wire logic [CAP_WIDTH-1:0]     cfg_data,
    output int                            fail_count,
    output int                            outstanding
);

    typedef struct {
        logic [KEY_WIDTH-1:0]     tag;
        logic [PAYLOAD_WIDTH-1:0] value;
    } line_t;

    // cached lines, most recently used first
    line_t       lru_lines[$];
    int unsigned lines_allowed = ENTRIES;
    resp_t       awaited_responses[$];
    int          errors = 0;

    // Response of one cache access; updates the line list as the block should
    function automatic resp_t cache_access(logic kind, logic [KEY_WIDTH-1:0] key,
                                           logic [PAYLOAD_WIDTH-1:0] pay);
        resp_t r;
        line_t ln;
        int    hit_at;
        r.status      = ST_MISS;
        r.data        = '0;
        r.evicted_key = '0;
        hit_at        = -1;
        foreach (lru_lines[i])
            if (hit_at < 0 && lru_lines[i].tag == key) hit_at = i;
        if (kind == KIND_LOOKUP) begin
            if (hit_at >= 0) begin
                ln = lru_lines[hit_at];
                lru_lines.delete(hit_at);
                lru_lines.insert(0, ln);
                r.status = ST_HIT;
                r.data   = ln.value;
            end
        end else if (lines_allowed == 0) begin
            r.status = ST_OFF;
        end else if (hit_at >= 0) begin
            // present key: no refresh of its recency
            r.status = ST_DUP;
        end else begin
            ln.tag   = key;
            ln.value = pay;
            if (lru_lines.size() < lines_allowed) begin
                r.status = ST_STORED;
            end else begin
                r.status      = ST_EVICT;
                r.evicted_key = lru_lines[$].tag;
                lru_lines.delete(lru_lines.size() - 1);
            end
            lru_lines.insert(0, ln);
        end
        return r;
    endfunction

    task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
            errors++;
        end
    endtask

    // Response beats are compared before the request beat of the same edge is predicted
    always @(posedge aclk) begin : monitor
        resp_t want;
        if (!aresetn) begin
            lru_lines.delete();
            awaited_responses.delete();
            lines_allowed = (CAP_RESET > ENTRIES) ? ENTRIES : CAP_RESET;
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_responses.size() == 0) begin
                    $display("%0t: response beat with none expected, status %0d",
                             $time, m_status);
                    errors++;
                end else begin
                    want = awaited_responses[0];
                    awaited_responses.delete(0);
                    check_field("status", 64'(want.status), 64'(m_status));
                    check_field("data", 64'(want.data), 64'(m_data));
                    check_field("evicted_key", 64'(want.evicted_key), 64'(m_evicted_key));
                end
            end
            // a capacity write empties the cache
            if (cfg_valid && cfg_ready) begin
                lines_allowed = (cfg_data > ENTRIES) ? ENTRIES : cfg_data;
                lru_lines.delete();
            end
            if (s_valid && s_ready)
                awaited_responses.insert(awaited_responses.size(),
                                         cache_access(s_kind, s_key, s_payload));
        end
        fail_count  <= errors;
        outstanding <= awaited_responses.size();
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Top of the LRU result cache bench: clock, reset, request and capacity stimulus,
// response back-pressure and the verdict. Depends on lrc_pkg, lru_cache_checker, the block.

module testbench
    import lrc_pkg::*;
();

    localparam int CYCLE_LIMIT   = 4_000_000;
    localparam int SETTLE_CYCLES = 600;
    localparam int SMALL_CAPS [10] = '{2, 3, 0, 5, 8, 1, 16, 4, 32, 6};

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     s_valid   = 1'b0;
    logic                     s_ready;
    logic                     s_kind    = KIND_LOOKUP;
    logic [KEY_WIDTH-1:0]     s_key     = '0;
    logic [PAYLOAD_WIDTH-1:0] s_payload = '0;
    logic                     m_valid;
    logic                     m_ready   = 1'b0;
    logic [STATUS_WIDTH-1:0]  m_status;
    logic [PAYLOAD_WIDTH-1:0] m_data;
    logic [KEY_WIDTH-1:0]     m_evicted_key;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CAP_WIDTH-1:0]     cfg_data  = '0;

    int fail_count;
    int outstanding;
    int cycle_count = 0;
    int stall_left  = 0;
    bit quiet       = 1'b0;

    logic [KEY_WIDTH-1:0] key_pool[$];

    lru_result_cache_unit uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_key         (s_key),
        .s_payload     (s_payload),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_data        (m_data),
        .m_evicted_key (m_evicted_key),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    lru_cache_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_key         (s_key),
        .s_payload     (s_payload),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_data        (m_data),
        .m_evicted_key (m_evicted_key),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Hang guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Response side: after each beat, hold ready low for a random number of cycles
    always @(posedge aclk) begin : sink
        if (!aresetn) begin
            stall_left = 0;
        end else if (m_valid && m_ready) begin
            stall_left = quiet ? 0 : $urandom_range(0, 6);
        end else if (stall_left > 0) begin
            stall_left--;
        end
        m_ready <= aresetn && (stall_left == 0);
    end

    function automatic logic [KEY_WIDTH-1:0] random_key();
        return {$urandom, $urandom};
    endfunction

    // One request beat, preceded by a random gap; valid stays up if the gap is zero
    task automatic send_item(logic kind, logic [KEY_WIDTH-1:0] key,
                             logic [PAYLOAD_WIDTH-1:0] pay);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_kind    <= kind;
        s_key     <= key;
        s_payload <= pay;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop sending, then wait for every response and a settling pause
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_capacity(logic [CAP_WIDTH-1:0] cap);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Random access on the first `used` pool keys, with the odd fresh key as noise
    task automatic random_access(int used);
        logic [KEY_WIDTH-1:0] k;
        if (used == 0 || $urandom_range(0, 9) == 0)
            k = random_key();
        else
            k = key_pool[$urandom_range(0, used - 1)];
        send_item(logic'($urandom_range(0, 1)), k, $urandom);
    endtask

    function automatic void fill_pool(int n);
        key_pool.delete();
        repeat (n) key_pool.insert(key_pool.size(), random_key());
    endfunction

    initial begin : stimulus
        logic [KEY_WIDTH-1:0] ka;
        logic [KEY_WIDTH-1:0] kb;
        int                   n_items;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: default capacity, key and payload extremes, hit, duplicate, miss
        send_item(KIND_LOOKUP, '0, '0);
        send_item(KIND_INSERT, '0, '0);
        send_item(KIND_INSERT, '1, '1);
        send_item(KIND_LOOKUP, '1, '0);
        send_item(KIND_LOOKUP, '0, '1);
        send_item(KIND_INSERT, '1, 32'h5);
        send_item(KIND_LOOKUP, '1, '0);
        send_item(KIND_LOOKUP, 64'h5555_5555_5555_5555, '0);
        send_item(KIND_INSERT, 64'h8000_0000_0000_0001, 32'h8000_0001);

        // Capacity zero: inserts disabled, store emptied by the write
        set_capacity(9'd0);
        send_item(KIND_INSERT, 64'h1234, 32'hABCD);
        send_item(KIND_LOOKUP, '1, '0);

        // Capacity one: each new key after the first evicts the last
        set_capacity(9'd1);
        ka = random_key();
        kb = ~ka;
        send_item(KIND_INSERT, ka, 32'hAAAA_5555);
        send_item(KIND_INSERT, kb, 32'h5555_AAAA);
        send_item(KIND_LOOKUP, ka, '0);
        send_item(KIND_LOOKUP, kb, '0);
        send_item(KIND_INSERT, kb, 32'h1);

        // Capacity above the entry count
        set_capacity(9'd511);
        send_item(KIND_INSERT, ka, 32'h7);
        send_item(KIND_INSERT, kb, 32'h8);
        send_item(KIND_LOOKUP, ka, '0);

        // Random phases at small capacities
        foreach (SMALL_CAPS[p]) begin
            set_capacity(CAP_WIDTH'(SMALL_CAPS[p]));
            quiet = ($urandom_range(0, 3) == 0);
            fill_pool(2 * SMALL_CAPS[p] + 3);
            n_items = $urandom_range(60, 80);
            repeat (n_items) random_access(key_pool.size());
        end

        // Fill well past the entry count at the largest setting, then churn
        set_capacity(9'd511);
        quiet = 1'b0;
        fill_pool(300);
        for (int i = 0; i < 300; i++) begin
            send_item(KIND_INSERT, key_pool[i], $urandom);
            if ($urandom_range(0, 2) == 0)
                send_item(KIND_LOOKUP, key_pool[$urandom_range(0, i)], $urandom);
            if (i == 150) quiet = 1'b1;
        end
        quiet = 1'b0;
        repeat (80) random_access(key_pool.size());

        // Back to the reset value with a short random run
        set_capacity(9'd256);
        fill_pool(12);
        repeat (40) random_access(key_pool.size());

        settle();
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
